// ===== sv/desa_pkg.sv =====
`timescale 1ns / 1ps
// desa_pkg: shared types and codes of the double-ended scratch allocator.
// No dependencies; imported by desa_ctrl, desa_datapath and the top level.
package desa_pkg;

    localparam int unsigned GUARD_BYTES = 16;   // reserved at each end of a section
    localparam int unsigned MIN_REQ     = 32;   // two guards, before alignment

    typedef enum logic [2:0] {
        KIND_BUFFER = 3'd0,
        KIND_STACK  = 3'd1,
        KIND_PUSH   = 3'd2,
        KIND_POP    = 3'd3,
        KIND_TOGGLE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NO_SPACE    = 3'd1,
        STAT_MARK_OVER   = 3'd2,
        STAT_MARK_UNDER  = 3'd3,
        STAT_MARK_HELD   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_SCALE  = 2'd2,
        ST_EXEC   = 2'd3
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] nbytes;
    } in_word_t;

    typedef struct packed {
        logic [16:0] offset;
        logic        section;
        logic [2:0]  status;
        logic [16:0] buffer_end;
        logic [16:0] peak_used;
        logic [31:0] generation;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic divide;    // quotient of the rounding step, marker read
        logic scale;     // quotient back to bytes
        logic commit;    // update state and load the result word
    } dp_cmd_t;

endpackage

// ===== sv/desa_ctrl.sv =====
`timescale 1ns / 1ps
// desa_ctrl: sequencing state machine and result-valid flag.
// Depends on desa_pkg.
module desa_ctrl
    import desa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_EXEC;
            ST_EXEC:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.divide  = 1'b0;
        cmd.scale   = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DIVIDE: cmd.divide = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_EXEC:   cmd.commit = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== sv/desa_datapath.sv =====
`timescale 1ns / 1ps
// desa_datapath: size rounding unit, region pointers, marker memory,
// toggle bookkeeping and the result register. Depends on desa_pkg.
module desa_datapath
    import desa_pkg::*;
#(
    parameter int unsigned MARKER_DEPTH  = 16,
    parameter int unsigned SECTION_BYTES = 65536,
    parameter int unsigned ALIGN_BYTES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  in_word_t    in_word,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    output out_word_t   out_word
);

    // pointer width, requested-size width, rounding width, compare width
    localparam int unsigned AW  = $clog2(SECTION_BYTES + 1);
    localparam int unsigned RQW = (AW > 17) ? AW : 17;
    localparam int unsigned XW  = RQW + 1;
    localparam int unsigned PW  = XW + 1;
    // reciprocal for divide by ALIGN_BYTES, exact for XW-bit dividends
    localparam int unsigned AL    = $clog2(ALIGN_BYTES);
    localparam int unsigned SH    = XW + AL;
    localparam int unsigned MW    = XW + 2;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam logic [MW-1:0] RECIP   = MW'(RECIP_L);
    localparam logic [XW-1:0] ALIGN_X = XW'(ALIGN_BYTES);
    localparam logic [XW-1:0] ALIGN_M1 = XW'(ALIGN_BYTES - 1);
    localparam int unsigned LO_SIZE =
        ((MIN_REQ + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    // marker store geometry
    localparam int unsigned MIW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(MARKER_DEPTH + 1);

    localparam logic [PW-1:0]  GUARD_P   = PW'(GUARD_BYTES);
    localparam logic [PW-1:0]  LO_P      = PW'(LO_SIZE);
    localparam logic [PW-1:0]  SEC_P     = PW'(SECTION_BYTES);
    localparam logic [CW-1:0]  DEPTH_C   = CW'(MARKER_DEPTH);
    localparam logic [RQW-1:0] REQ_RESET = RQW'(SECTION_BYTES);

    // captured item
    logic [2:0]  kind_reg;
    logic [15:0] nbytes_reg;

    // rounding unit
    logic [RQW-1:0]   req_reg;
    logic [XW-1:0]    rnd_src;
    logic [XW-1:0]    rnd_sum;
    logic [XW+MW-1:0] rnd_prod;
    logic [XW-1:0]    quot_reg;
    logic [2*XW-1:0]  scale_prod;
    logic [XW-1:0]    need_reg;

    // allocator state
    logic [AW-1:0] buf_top_reg, buf_top_next;
    logic [AW-1:0] stk_top_reg, stk_top_next;
    logic [CW-1:0] mark_cnt_reg, mark_cnt_next;
    logic          section_reg, section_next;
    logic [AW-1:0] peak_reg, peak_next;
    logic [31:0]   gen_reg, gen_next;

    // marker memory
    logic [AW-1:0] mark_mem [MARKER_DEPTH];
    logic [AW-1:0] mark_rd_reg;
    logic [CW-1:0] mark_rd_cnt;
    logic          mark_wr;

    // commit-time values
    logic [PW-1:0] bt_p, st_p, need_p, eff_p;
    logic          fits;
    logic [PW-1:0] offset_p;
    status_t       status;
    out_word_t     out_word_reg;

    // --- rounding: ceil(n / ALIGN) by reciprocal, then times ALIGN ---
    assign rnd_src  = (kind_reg == KIND_TOGGLE) ? XW'(req_reg) : XW'(nbytes_reg);
    assign rnd_sum  = rnd_src + ALIGN_M1;
    assign rnd_prod = (XW+MW)'(rnd_sum) * (XW+MW)'(RECIP);
    assign scale_prod = (2*XW)'(quot_reg) * (2*XW)'(ALIGN_X);
    assign mark_rd_cnt = mark_cnt_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= in_word.kind;
            nbytes_reg <= in_word.nbytes;
        end
        if (cmd.divide) begin
            quot_reg    <= rnd_prod[SH +: XW];
            mark_rd_reg <= mark_mem[mark_rd_cnt[MIW-1:0]];
        end
        if (cmd.scale) begin
            need_reg <= scale_prod[XW-1:0];
        end
        if (mark_wr) begin
            mark_mem[mark_cnt_reg[MIW-1:0]] <= stk_top_reg;
        end
        if (cmd.commit) begin
            out_word_reg <= out_word_t'{
                offset:     offset_p[16:0],
                section:    section_next,
                status:     status,
                buffer_end: 17'(buf_top_next),
                peak_used:  17'(peak_next),
                generation: gen_next
            };
        end
    end

    // --- state update ---
    assign bt_p   = PW'(buf_top_reg);
    assign st_p   = PW'(stk_top_reg);
    assign need_p = PW'(need_reg);
    assign fits   = (bt_p + need_p) <= st_p;

    // section size: aligned request clamped to minimum and section bytes
    always_comb begin
        eff_p = need_p;
        if (eff_p < LO_P)  eff_p = LO_P;
        if (eff_p > SEC_P) eff_p = SEC_P;
    end

    always_comb begin
        buf_top_next  = buf_top_reg;
        stk_top_next  = stk_top_reg;
        mark_cnt_next = mark_cnt_reg;
        section_next  = section_reg;
        peak_next     = peak_reg;
        gen_next      = gen_reg;
        offset_p      = '0;
        status        = STAT_OK;
        mark_wr       = 1'b0;
        unique case (kind_reg)
            KIND_BUFFER: begin
                if (!fits) begin
                    status = STAT_NO_SPACE;
                end else begin
                    offset_p     = bt_p;
                    buf_top_next = AW'(bt_p + need_p);
                end
            end
            KIND_STACK: begin
                if (!fits) begin
                    status = STAT_NO_SPACE;
                end else begin
                    offset_p     = st_p - need_p;
                    stk_top_next = AW'(st_p - need_p);
                end
            end
            KIND_PUSH: begin
                if (mark_cnt_reg >= DEPTH_C) begin
                    status = STAT_MARK_OVER;
                end else begin
                    mark_wr       = cmd.commit;
                    mark_cnt_next = mark_cnt_reg + CW'(1);
                end
            end
            KIND_POP: begin
                if (mark_cnt_reg == '0) begin
                    status = STAT_MARK_UNDER;
                end else begin
                    mark_cnt_next = mark_rd_cnt;
                    stk_top_next  = mark_rd_reg;
                end
            end
            KIND_TOGGLE: begin
                if (mark_cnt_reg != '0) begin
                    status = STAT_MARK_HELD;
                end else begin
                    if (buf_top_reg > peak_reg) peak_next = buf_top_reg;
                    section_next  = !section_reg;
                    buf_top_next  = AW'(GUARD_P);
                    stk_top_next  = AW'(eff_p - GUARD_P);
                    mark_cnt_next = '0;
                    gen_next      = gen_reg + 32'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg      <= REQ_RESET;
            buf_top_reg  <= AW'(GUARD_P);
            stk_top_reg  <= AW'(SEC_P - GUARD_P);
            mark_cnt_reg <= '0;
            section_reg  <= 1'b0;
            peak_reg     <= '0;
            gen_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                req_reg <= RQW'(cfg_wr_data);
            end
            if (cmd.commit) begin
                buf_top_reg  <= buf_top_next;
                stk_top_reg  <= stk_top_next;
                mark_cnt_reg <= mark_cnt_next;
                section_reg  <= section_next;
                peak_reg     <= peak_next;
                gen_reg      <= gen_next;
            end
        end
    end

    assign out_word = out_word_reg;

endmodule

// ===== sv/double_ended_scratch_allocator_unit.sv =====
`timescale 1ns / 1ps
// double_ended_scratch_allocator_unit: top level of the offset-only scratch
// allocator. Depends on desa_pkg, desa_ctrl and desa_datapath.
//
//   channel   ports                          word / data
//   --------  -----------------------------  ---------------------------------
//   request   s_valid, s_ready, s_word       in_word_t  {kind, nbytes}
//   result    m_valid, m_ready, m_word       out_word_t {offset .. generation}
//   config    cfg_wr_en, cfg_wr_data         requested_size, 17 bits
//
// Steps: once its word is accepted, the result goes through the reciprocal
// multiply, the scale by the alignment and the single update step, and is then
// valid; one word is in flight at a time, so a new word is taken only after the update.
// Reset: aresetn is synchronous, active low; no clearing pass is needed.
// Stalls: the result sits in its own register, so a new request is taken
// while m_valid waits; the update cycle holds while that register is full and m_ready is low.
module double_ended_scratch_allocator_unit
    import desa_pkg::*;
#(
    parameter int unsigned MARKER_DEPTH  = 16,
    parameter int unsigned SECTION_BYTES = 65536,
    parameter int unsigned ALIGN_BYTES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request words
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word,
    // requested section size, applied at the next toggle
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    dp_cmd_t cmd;

    // sequencing: idle -> divide -> scale -> exec (holds on a full result reg)
    desa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // pointers, marker store, toggle bookkeeping and the result register
    desa_datapath #(
        .MARKER_DEPTH  (MARKER_DEPTH),
        .SECTION_BYTES (SECTION_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_word     (s_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_word    (m_word)
    );

endmodule

// ===== verif/desa_checker.sv =====
`timescale 1ns / 1ps
// desa_checker: watches the request, result and size ports of the scratch
// allocator, predicts each result word and compares it. Depends on desa_pkg.
module desa_checker
    import desa_pkg::*;
#(
    parameter int unsigned MARKER_DEPTH  = 16,
    parameter int unsigned SECTION_BYTES = 65536,
    parameter int unsigned ALIGN_BYTES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_word,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    output int          fail_count,
    output int          pending,
    output int          checked_count
);

    // mirrored allocator state
    logic [16:0] req_size;
    logic [16:0] buf_top;
    logic [16:0] stk_top;
    logic [16:0] peak;
    logic [16:0] marks [MARKER_DEPTH];
    int unsigned mark_cnt;
    logic        act_sec;
    logic [16:0] sec_size [2];
    logic [31:0] gen_count;

    out_word_t   result_q [$];
    int          n_fail;
    int          n_checked;

    function automatic int unsigned align_up(input int unsigned n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic logic [16:0] clamp_size(input int unsigned req);
        int unsigned lo;
        int unsigned s;
        lo = align_up(2 * GUARD_BYTES);
        s  = align_up(req);
        if (s < lo) s = lo;
        if (s > SECTION_BYTES) s = SECTION_BYTES;
        return s[16:0];
    endfunction

    task automatic open_section();
        buf_top  = 17'(GUARD_BYTES);
        stk_top  = 17'(sec_size[act_sec] - GUARD_BYTES);
        mark_cnt = 0;
    endtask

    task automatic predict_word(input in_word_t w, output out_word_t r);
        int unsigned need;
        need     = align_up(w.nbytes);
        r        = '0;
        r.status = STAT_OK;
        case (w.kind)
            KIND_BUFFER: begin
                if (buf_top + need > stk_top) begin
                    r.status = STAT_NO_SPACE;
                end else begin
                    r.offset = buf_top;
                    buf_top  = 17'(buf_top + need);
                end
            end
            KIND_STACK: begin
                if (buf_top + need > stk_top) begin
                    r.status = STAT_NO_SPACE;
                end else begin
                    stk_top  = 17'(stk_top - need);
                    r.offset = stk_top;
                end
            end
            KIND_PUSH: begin
                if (mark_cnt >= MARKER_DEPTH) begin
                    r.status = STAT_MARK_OVER;
                end else begin
                    marks[mark_cnt] = stk_top;
                    mark_cnt++;
                end
            end
            KIND_POP: begin
                if (mark_cnt == 0) begin
                    r.status = STAT_MARK_UNDER;
                end else begin
                    mark_cnt--;
                    stk_top = marks[mark_cnt];
                end
            end
            KIND_TOGGLE: begin
                if (mark_cnt != 0) begin
                    r.status = STAT_MARK_HELD;
                end else begin
                    if (buf_top > peak) peak = buf_top;
                    sec_size[~act_sec] = clamp_size(req_size);
                    act_sec = ~act_sec;
                    open_section();
                    gen_count++;
                end
            end
            default: ;  // unused kinds leave everything alone
        endcase
        r.section    = act_sec;
        r.buffer_end = buf_top;
        r.peak_used  = peak;
        r.generation = gen_count;
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_word_t exp_w;
        out_word_t new_w;
        if (!aresetn) begin
            req_size    = 17'(SECTION_BYTES);
            sec_size[0] = clamp_size(SECTION_BYTES);
            sec_size[1] = sec_size[0];
            for (int i = 0; i < MARKER_DEPTH; i++) marks[i] = '0;
            act_sec   = 1'b0;
            peak      = '0;
            gen_count = '0;
            open_section();
            result_q.delete();
            n_fail    = 0;
            n_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    n_fail++;
                end else begin
                    exp_w = result_q.pop_front();
                    check_field("offset",     exp_w.offset,     m_word.offset);
                    check_field("section",    exp_w.section,    m_word.section);
                    check_field("status",     exp_w.status,     m_word.status);
                    check_field("buffer_end", exp_w.buffer_end, m_word.buffer_end);
                    check_field("peak_used",  exp_w.peak_used,  m_word.peak_used);
                    check_field("generation", exp_w.generation, m_word.generation);
                    n_checked++;
                end
            end
            if (cfg_wr_en) req_size = cfg_wr_data;
            if (s_valid && s_ready) begin
                predict_word(s_word, new_w);
                result_q.push_back(new_w);
            end
        end
        fail_count    <= n_fail;
        pending       <= result_q.size();
        checked_count <= n_checked;
    end

endmodule

// ===== verif/tb_double_ended_scratch_allocator_unit.sv =====
`timescale 1ns / 1ps
// tb_double_ended_scratch_allocator_unit: stimulus and verdict for the scratch
// allocator. Depends on desa_pkg, desa_checker and the allocator RTL.
module tb_double_ended_scratch_allocator_unit;
    import desa_pkg::*;

    localparam int unsigned MARKER_DEPTH  = 16;
    localparam int unsigned SECTION_BYTES = 65536;
    localparam int unsigned ALIGN_BYTES   = 16;

    localparam int PHASES         = 8;     // size settings after the directed part
    localparam int WORDS_PER_PHASE = 72;
    localparam int HOLD_AT        = 60;    // result count at which the sink backs off
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 250000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;

    int fail_count;
    int pending;
    int checked_count;

    int cycle_count  = 0;
    int words_sent   = 0;   // every accepted request word
    int real_words   = 0;   // request words with a defined kind
    int settings_cnt = 0;
    bit src_steady   = 1'b0;   // sender stretch with no gaps
    bit sink_steady  = 1'b0;   // receiver stretch with no stalls
    bit hold_done    = 1'b0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    double_ended_scratch_allocator_unit #(
        .MARKER_DEPTH  (MARKER_DEPTH),
        .SECTION_BYTES (SECTION_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    desa_checker #(
        .MARKER_DEPTH  (MARKER_DEPTH),
        .SECTION_BYTES (SECTION_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request word. The gap is drawn per word; with no gap the
    // valid stays up across words and only the payload changes.
    task automatic send_word(input logic [2:0] kind, input logic [15:0] nbytes);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_word  <= '{kind: kind, nbytes: nbytes};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (kind <= KIND_TOGGLE) real_words++;
        if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    endtask

    // Mostly small sizes so many blocks fit; a few zero, maximum and aligned.
    function automatic logic [15:0] draw_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)  return 16'd0;
        if (pick < 10) return 16'hFFFF;
        if (pick < 15) return 16'($urandom_range(0, 65535));
        if (pick < 25) return 16'(16 * $urandom_range(1, 64));
        return 16'($urandom_range(1, 2048));
    endfunction

    function automatic logic [2:0] draw_alloc_kind();
        return $urandom_range(0, 1) ? KIND_STACK : KIND_BUFFER;
    endfunction

    task automatic marker_burst(input int pushes, input int pops);
        repeat (pushes) send_word(KIND_PUSH, 16'($urandom_range(0, 65535)));
        repeat (pops)   send_word(KIND_POP, 16'($urandom_range(0, 65535)));
    endtask

    // Drop valid and wait for every prediction to be matched before touching the size register.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_size(input logic [16:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_cnt++;
    endtask

    // Edges on the default 64 KiB section: zero-byte grants, sub-alignment
    // rounding, overflow of both ends, marker underflow, toggle refused
    // while a marker is held, unused kinds, exact fit and a pair of toggles.
    task automatic run_directed();
        send_word(KIND_BUFFER, 16'd0);
        send_word(KIND_BUFFER, 16'd1);
        send_word(KIND_STACK,  16'd17);
        send_word(KIND_STACK,  16'd0);
        send_word(KIND_BUFFER, 16'hFFFF);
        send_word(KIND_STACK,  16'hFFFF);
        send_word(KIND_POP,    16'd0);
        send_word(KIND_PUSH,   16'hFFFF);
        send_word(KIND_STACK,  16'd256);
        send_word(KIND_TOGGLE, 16'd0);
        send_word(KIND_POP,    16'd0);
        send_word(3'd5,        16'hFFFF);
        send_word(3'd6,        16'h5A5A);
        send_word(3'd7,        16'd0);
        send_word(KIND_BUFFER, 16'd65456);  // closes the gap exactly
        send_word(KIND_STACK,  16'd1);
        send_word(KIND_STACK,  16'd0);
        send_word(KIND_TOGGLE, 16'hFFFF);
        send_word(KIND_BUFFER, 16'd7);
        send_word(KIND_TOGGLE, 16'd0);
    endtask

    // Random sequences: mostly allocation runs and balanced marker frames,
    // with toggles to recycle sections, plus noise and ignored kinds.
    task automatic run_random(input int count);
        int target;
        int pick;
        int len;
        int pushes;
        target = real_words + count;
        while (real_words < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = $urandom_range(1, 6);
                repeat (len) send_word(draw_alloc_kind(), draw_size());
            end else if (pick < 62) begin
                send_word(KIND_PUSH, 16'($urandom_range(0, 65535)));
                len = $urandom_range(0, 4);
                repeat (len) send_word(draw_alloc_kind(), draw_size());
                if ($urandom_range(0, 9) == 0) send_word(KIND_TOGGLE, draw_size());
                send_word(KIND_POP, 16'($urandom_range(0, 65535)));
            end else if (pick < 65) begin
                // may leave markers behind or run past either end
                pushes = $urandom_range(10, 18);
                marker_burst(pushes, $urandom_range(pushes - 1, pushes + 1));
            end else if (pick < 77) begin
                send_word(KIND_TOGGLE, 16'($urandom_range(0, 65535)));
            end else if (pick < 95) begin
                send_word(3'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)));
            end else begin
                send_word(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: per-word stall, plus one long hold so the result
    // register fills and the request side backs up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == HOLD_AT && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (sink_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if ($urandom_range(0, 49) == 0) sink_steady = !sink_steady;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [16:0] sizes [PHASES];
        // minimum, maximum, below the floor, all ones, unaligned, odd, random
        sizes[0] = 17'd32;
        sizes[1] = 17'd65536;
        sizes[2] = 17'd0;
        sizes[3] = 17'h1FFFF;
        sizes[4] = 17'd1000;
        sizes[5] = 17'd257;
        sizes[6] = 17'($urandom_range(32, 65536));
        sizes[7] = 17'($urandom_range(0, 131071));

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_word      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_size(sizes[ph]);
            // drive the marker stack past full and back past empty once
            if (ph == 0) marker_burst(MARKER_DEPTH + 1, MARKER_DEPTH + 1);
            run_random(WORDS_PER_PHASE);
        end
        settle();

        $display("Run covered %0d request words (%0d with defined kinds) across %0d size settings.",
                 words_sent, real_words, settings_cnt);
        $display("%0d result words compared; receiver hold of %0d cycles applied: %0d.",
                 checked_count, HOLD_CYCLES, hold_done);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
